/* rtl/core/pdc_pkg.sv */
// shared types and constants for the pwm duty-cycle co2 capture block
// widths, register indexes, status codes and controller/datapath structs
// no dependencies
`timescale 1ns / 1ps

package pdc_pkg;

	localparam int COUNT_BITS = 21;

	localparam int FS_W       = 14;
	localparam int OFF_W      = 17;
	localparam int TO_W       = 21;
	localparam int WARM_W     = 26;
	localparam int ST_W       = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 26;

	// signed numerator and denominator widths
	localparam int NUM_W  = ((COUNT_BITS > OFF_W) ? COUNT_BITS : OFF_W) + 1;
	localparam int DEN_W  = ((COUNT_BITS + 1 > OFF_W) ? COUNT_BITS + 1 : OFF_W) + 1;
	localparam int PROD_W = FS_W + NUM_W - 1;
	localparam int DIV_CNT_W = $clog2(PROD_W + 1);
	localparam int CMP_W  = ((COUNT_BITS > TO_W) ? COUNT_BITS : TO_W) + 1;

	localparam logic [FS_W-1:0]   FULL_SCALE_RST    = FS_W'(5000);
	localparam logic [OFF_W-1:0]  HIGH_OFFSET_RST   = OFF_W'(2000);
	localparam logic [OFF_W-1:0]  PERIOD_OFFSET_RST = OFF_W'(4000);
	localparam logic [TO_W-1:0]   EDGE_TIMEOUT_RST  = TO_W'(1060000);
	localparam logic [WARM_W-1:0] WARMUP_TICKS_RST  = WARM_W'(60000000);

	localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_OFFSET   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_OFFSET = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EDGE_TIMEOUT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_TICKS  = 3'd4;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_NO_RISE  = 3'd1;
	localparam logic [ST_W-1:0] ST_NO_FALL  = 3'd2;
	localparam logic [ST_W-1:0] ST_LOW_LONG = 3'd3;
	localparam logic [ST_W-1:0] ST_DEGEN    = 3'd4;

	typedef struct packed {
		logic accept;
		logic div_start;
		logic load_out;
	} pdc_cmd_t;

	typedef struct packed {
		logic emit;
		logic need_div;
		logic div_busy;
		logic out_free;
	} pdc_sts_t;

endpackage

/* rtl/core/pdc_if.sv */
// valid/ready channel interfaces for pin samples and results
// depends on pdc_pkg
`timescale 1ns / 1ps

interface pdc_in_if;
	logic valid;
	logic ready;
	logic pin_level;

	modport source(output valid, output pin_level, input ready);
	modport sink(input valid, input pin_level, output ready);
endinterface

interface pdc_out_if;
	logic                        valid;
	logic                        ready;
	logic [pdc_pkg::FS_W-1:0]    ppm;
	logic [pdc_pkg::ST_W-1:0]    status;
	logic                        warming;

	modport source(output valid, output ppm, output status, output warming, input ready);
	modport sink(input valid, input ppm, input status, input warming, output ready);
endinterface

/* rtl/core/pdc_div.sv */
// restoring divider, one quotient bit per cycle
// depends on pdc_pkg
`timescale 1ns / 1ps

module pdc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pdc_pkg::PROD_W-1:0]    dividend,
	input  logic [pdc_pkg::DEN_W-2:0]     divisor,
	output logic                          busy,
	output logic [pdc_pkg::PROD_W-1:0]    quotient
);

	localparam int PW = pdc_pkg::PROD_W;
	localparam int DW = pdc_pkg::DEN_W;

	logic [PW-1:0]                   quo_q;
	logic [DW-2:0]                   rem_q;
	logic [DW-2:0]                   den_q;
	logic [pdc_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic                            busy_q;
	logic [DW-1:0]                   shifted;
	logic [DW-1:0]                   diff;
	logic                            fits;

	assign shifted = {rem_q, quo_q[PW-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= pdc_pkg::DIV_CNT_W'(PW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == pdc_pkg::DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[PW-2:0], fits};
			rem_q <= fits ? diff[DW-2:0] : shifted[DW-2:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

/* rtl/core/pdc_dp.sv */
// datapath: config registers, edge and time counters, ppm arithmetic, output register
// depends on pdc_pkg and pdc_div
`timescale 1ns / 1ps

module pdc_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pdc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pdc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              pin_level,
	input  pdc_pkg::pdc_cmd_t                 cmd,
	output pdc_pkg::pdc_sts_t                 sts,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [pdc_pkg::FS_W-1:0]          ppm,
	output logic [pdc_pkg::ST_W-1:0]          status,
	output logic                              warming
);

	localparam int CB  = pdc_pkg::COUNT_BITS;
	localparam int NW  = pdc_pkg::NUM_W;
	localparam int DW  = pdc_pkg::DEN_W;
	localparam int PW  = pdc_pkg::PROD_W;
	localparam int CW  = pdc_pkg::CMP_W;
	localparam int WW  = pdc_pkg::WARM_W;
	localparam int FW  = pdc_pkg::FS_W;

	typedef enum logic [1:0] {
		PH_RISE = 2'd0,
		PH_HIGH = 2'd1,
		PH_LOW  = 2'd2
	} phase_t;

	logic [FW-1:0]               full_scale_q;
	logic [pdc_pkg::OFF_W-1:0]   high_offset_q;
	logic [pdc_pkg::OFF_W-1:0]   period_offset_q;
	logic [pdc_pkg::TO_W-1:0]    edge_timeout_q;
	logic [WW-1:0]               warmup_ticks_q;

	phase_t                      phase_q, phase_n;
	logic                        prev_q;
	logic [CB-1:0]               high_q, high_n;
	logic [CB-1:0]               low_q, low_n;
	logic [CB-1:0]               wait_q, wait_n;
	logic [WW-1:0]               warm_q, warm_n;

	logic                        rise, fall, timeout;
	logic [CB-1:0]               wait_inc;
	logic signed [NW-1:0]        num;
	logic signed [DW-1:0]        den;
	logic                        num_pos, den_pos;
	logic                        emit, need_div;
	logic [pdc_pkg::ST_W-1:0]    st;

	logic [NW-2:0]               num_s1;
	logic [DW-2:0]               den_s1;
	logic [pdc_pkg::ST_W-1:0]    st_s1;
	logic                        need_div_s1;
	logic                        warm_s1;

	logic [PW-1:0]               product;
	logic [PW-1:0]               quotient;
	logic                        div_busy;
	logic [FW-1:0]               ppm_clamped;

	logic                        out_valid_q;
	logic [FW-1:0]               ppm_q;
	logic [pdc_pkg::ST_W-1:0]    status_q;
	logic                        warming_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q    <= pdc_pkg::FULL_SCALE_RST;
			high_offset_q   <= pdc_pkg::HIGH_OFFSET_RST;
			period_offset_q <= pdc_pkg::PERIOD_OFFSET_RST;
			edge_timeout_q  <= pdc_pkg::EDGE_TIMEOUT_RST;
			warmup_ticks_q  <= pdc_pkg::WARMUP_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pdc_pkg::CFG_FULL_SCALE:    full_scale_q    <= cfg_data[FW-1:0];
				pdc_pkg::CFG_HIGH_OFFSET:   high_offset_q   <= cfg_data[pdc_pkg::OFF_W-1:0];
				pdc_pkg::CFG_PERIOD_OFFSET: period_offset_q <= cfg_data[pdc_pkg::OFF_W-1:0];
				pdc_pkg::CFG_EDGE_TIMEOUT:  edge_timeout_q  <= cfg_data[pdc_pkg::TO_W-1:0];
				pdc_pkg::CFG_WARMUP_TICKS:  warmup_ticks_q  <= cfg_data[WW-1:0];
				default: ;
			endcase
		end
	end

	// per-item next state
	assign rise     = !prev_q && pin_level;
	assign fall     = prev_q && !pin_level;
	assign wait_inc = (wait_q != '1) ? wait_q + 1'b1 : wait_q;
	assign timeout  = CW'(wait_inc) >= CW'(edge_timeout_q);
	assign warm_n   = (warm_q != '1) ? warm_q + 1'b1 : warm_q;

	assign num     = NW'(high_q) - NW'(high_offset_q);
	assign den     = DW'(high_q) + DW'(low_q) - DW'(period_offset_q);
	assign num_pos = !num[NW-1] && (num != '0);
	assign den_pos = !den[DW-1] && (den != '0);

	always_comb begin
		phase_n  = phase_q;
		high_n   = high_q;
		low_n    = low_q;
		wait_n   = wait_q;
		emit     = 1'b0;
		need_div = 1'b0;
		st       = pdc_pkg::ST_OK;
		case (phase_q)
			PH_HIGH: begin
				if (fall) begin
					phase_n = PH_LOW;
					low_n   = CB'(1);
					wait_n  = '0;
				end else begin
					high_n = (high_q != '1) ? high_q + 1'b1 : high_q;
					wait_n = wait_inc;
					if (timeout) begin
						emit = 1'b1;
						st   = pdc_pkg::ST_NO_FALL;
					end
				end
			end
			PH_LOW: begin
				if (rise) begin
					emit    = 1'b1;
					phase_n = PH_RISE;
					wait_n  = '0;
					if (!den_pos) begin
						st = pdc_pkg::ST_DEGEN;
					end else begin
						need_div = num_pos;
					end
				end else begin
					low_n  = (low_q != '1) ? low_q + 1'b1 : low_q;
					wait_n = wait_inc;
					if (timeout) begin
						emit = 1'b1;
						st   = pdc_pkg::ST_LOW_LONG;
					end
				end
			end
			default: begin
				phase_n = PH_RISE;
				if (rise) begin
					phase_n = PH_HIGH;
					high_n  = CB'(1);
					low_n   = '0;
					wait_n  = '0;
				end else begin
					wait_n = wait_inc;
					if (timeout) begin
						emit = 1'b1;
						st   = pdc_pkg::ST_NO_RISE;
					end
				end
			end
		endcase
		if (emit && (st != pdc_pkg::ST_OK)) begin
			phase_n = PH_RISE;
			wait_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RISE;
			prev_q  <= 1'b1;
			high_q  <= '0;
			low_q   <= '0;
			wait_q  <= '0;
			warm_q  <= '0;
		end else if (cmd.accept) begin
			phase_q <= phase_n;
			prev_q  <= pin_level;
			high_q  <= high_n;
			low_q   <= low_n;
			wait_q  <= wait_n;
			warm_q  <= warm_n;
		end
	end

	// operands and result fields of the item in flight
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			num_s1      <= num[NW-2:0];
			den_s1      <= den[DW-2:0];
			st_s1       <= st;
			need_div_s1 <= need_div;
			warm_s1     <= warm_n < warmup_ticks_q;
		end
	end

	assign product = PW'(full_scale_q) * PW'(num_s1);

	pdc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (product),
		.divisor  (den_s1),
		.busy     (div_busy),
		.quotient (quotient)
	);

	assign ppm_clamped = (quotient > PW'(full_scale_q)) ? full_scale_q : quotient[FW-1:0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			ppm_q     <= ((st_s1 == pdc_pkg::ST_OK) && need_div_s1) ? ppm_clamped : '0;
			status_q  <= st_s1;
			warming_q <= warm_s1;
		end
	end

	assign sts.emit     = emit;
	assign sts.need_div = need_div;
	assign sts.div_busy = div_busy;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign ppm       = ppm_q;
	assign status    = status_q;
	assign warming   = warming_q;

endmodule

/* rtl/core/pdc_ctrl.sv */
// controller: sequences item acceptance, division and result hand-off
// depends on pdc_pkg
`timescale 1ns / 1ps

module pdc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  pdc_pkg::pdc_sts_t      sts,
	output pdc_pkg::pdc_cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV_START,
		S_DIV_RUN,
		S_PUT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.accept    = (state_q == S_IDLE) && in_valid;
		cmd.div_start = (state_q == S_DIV_START);
		cmd.load_out  = (state_q == S_PUT) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && sts.emit) begin
						state_q <= sts.need_div ? S_DIV_START : S_PUT;
					end
				end
				S_DIV_START: begin
					state_q <= S_DIV_RUN;
				end
				S_DIV_RUN: begin
					if (!sts.div_busy) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/pwm_duty_co2_capture.sv */
// pwm duty-cycle co2 capture: a tick with no result leaves the block ready for the next;
// any other result is loaded into the output register and the next tick is taken only
// after that load; a reading that needs the divider first passes the divider start and
// run states; an unread result at the output delays both
// reset clears counters, phase and output valid and restores register defaults
// depends on pdc_pkg, pdc_if, pdc_div, pdc_dp, pdc_ctrl
`timescale 1ns / 1ps

module pwm_duty_co2_capture (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pdc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pdc_pkg::CFG_DATA_W-1:0]    cfg_data,
	pdc_in_if.sink                            sample,
	pdc_out_if.source                         result
);

	pdc_pkg::pdc_cmd_t cmd;
	pdc_pkg::pdc_sts_t sts;

	pdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pdc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pin_level (sample.pin_level),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.ppm       (result.ppm),
		.status    (result.status),
		.warming   (result.warming)
	);

endmodule

/* tb/tb_pwm_duty_co2_capture.sv */
// testbench for pwm_duty_co2_capture: drives pin samples, predicts each reading and checks it
// directed edge and timeout cases, then random pulse trains under several register settings
// depends on pdc_pkg, pdc_if and the rtl of the block
`timescale 1ns / 1ps

module tb_pwm_duty_co2_capture;
	import pdc_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 60;
	localparam logic [WARM_W-1:0] WARM_MAX = '1;

	typedef enum logic [1:0] {PH_WAIT_RISE, PH_HIGH, PH_LOW, PH_SPARE} capture_phase_e;

	typedef struct packed {
		logic [FS_W-1:0] ppm;
		logic [ST_W-1:0] status;
		logic            warming;
	} reading_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pdc_in_if  sample_ch ();
	pdc_out_if result_ch ();

	pwm_duty_co2_capture uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// register mirror
	logic [FS_W-1:0]   fs_reg      = FULL_SCALE_RST;
	logic [OFF_W-1:0]  hi_off_reg  = HIGH_OFFSET_RST;
	logic [OFF_W-1:0]  per_off_reg = PERIOD_OFFSET_RST;
	logic [TO_W-1:0]   timeout_reg = EDGE_TIMEOUT_RST;
	logic [WARM_W-1:0] warmup_reg  = WARMUP_TICKS_RST;

	// capture state
	capture_phase_e        cap_phase = PH_WAIT_RISE;
	logic                  prev_lvl  = 1'b1;
	logic [COUNT_BITS-1:0] hi_cnt    = '0;
	logic [COUNT_BITS-1:0] lo_cnt    = '0;
	logic [COUNT_BITS-1:0] wait_cnt  = '0;
	logic [WARM_W-1:0]     warm_cnt  = '0;

	logic     pin_backlog[$];
	reading_t readings_due[$];

	int  errors = 0;
	int  send_gap = 0;
	int  recv_gap = 0;
	int  quiet_cycles = 0;
	bit  idle_on = 1'b0;
	bit  stall_on = 1'b0;

	function automatic logic [COUNT_BITS-1:0] bump(logic [COUNT_BITS-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic void track_sample(logic lvl);
		logic     rise, fall, emit;
		longint   num, den, q;
		reading_t r;
		rise = !prev_lvl && lvl;
		fall = prev_lvl && !lvl;
		emit = 1'b0;
		r = '0;
		r.status = ST_OK;
		prev_lvl = lvl;
		if (warm_cnt != WARM_MAX)
			warm_cnt++;
		case (cap_phase)
			PH_HIGH: begin
				if (fall) begin
					cap_phase = PH_LOW;
					lo_cnt = COUNT_BITS'(1);
					wait_cnt = '0;
				end else begin
					hi_cnt = bump(hi_cnt);
					wait_cnt = bump(wait_cnt);
					if (wait_cnt >= timeout_reg) begin
						emit = 1'b1;
						r.status = ST_NO_FALL;
					end
				end
			end
			PH_LOW: begin
				if (rise) begin
					emit = 1'b1;
					num = longint'(hi_cnt) - longint'(hi_off_reg);
					den = longint'(hi_cnt) + longint'(lo_cnt) - longint'(per_off_reg);
					if (den <= 0) begin
						r.status = ST_DEGEN;
					end else if (num > 0) begin
						q = longint'(fs_reg) * num / den;
						if (q > longint'(fs_reg))
							q = longint'(fs_reg);
						r.ppm = q[FS_W-1:0];
					end
					cap_phase = PH_WAIT_RISE;
					wait_cnt = '0;
				end else begin
					lo_cnt = bump(lo_cnt);
					wait_cnt = bump(wait_cnt);
					if (wait_cnt >= timeout_reg) begin
						emit = 1'b1;
						r.status = ST_LOW_LONG;
					end
				end
			end
			default: begin
				cap_phase = PH_WAIT_RISE;
				if (rise) begin
					cap_phase = PH_HIGH;
					hi_cnt = COUNT_BITS'(1);
					lo_cnt = '0;
					wait_cnt = '0;
				end else begin
					wait_cnt = bump(wait_cnt);
					if (wait_cnt >= timeout_reg) begin
						emit = 1'b1;
						r.status = ST_NO_RISE;
					end
				end
			end
		endcase
		if (emit) begin
			if (r.status != ST_OK) begin
				r.ppm = '0;
				cap_phase = PH_WAIT_RISE;
				wait_cnt = '0;
			end
			r.warming = (warm_cnt < warmup_reg);
			readings_due.push_back(r);
		end
	endfunction

	function automatic void add_levels(logic lvl, int n);
		repeat (n) pin_backlog.push_back(lvl);
	endfunction

	function automatic int add_pulse(int h, int l);
		add_levels(1'b1, h);
		add_levels(1'b0, l);
		return h + l;
	endfunction

	// mostly pulse trains, some long flat stretches and bit noise
	function automatic void queue_random(int n);
		int added, r, len;
		added = 0;
		while (added < n) begin
			r = $urandom_range(0, 9);
			if (r < 7) begin
				added += add_pulse($urandom_range(1, 12), $urandom_range(1, 12));
			end else if (r == 7) begin
				len = $urandom_range(20, 60);
				add_levels(1'($urandom_range(0, 1)), len);
				added += len;
			end else begin
				len = $urandom_range(1, 8);
				repeat (len) pin_backlog.push_back(1'($urandom_range(0, 1)));
				added += len;
			end
		end
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_FULL_SCALE:    fs_reg = val[FS_W-1:0];
			CFG_HIGH_OFFSET:   hi_off_reg = val[OFF_W-1:0];
			CFG_PERIOD_OFFSET: per_off_reg = val[OFF_W-1:0];
			CFG_EDGE_TIMEOUT:  timeout_reg = val[TO_W-1:0];
			CFG_WARMUP_TICKS:  warmup_reg = val[WARM_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input int fs, input int ho, input int po, input int to, input int wu);
		write_reg(CFG_FULL_SCALE, CFG_DATA_W'(fs));
		write_reg(CFG_HIGH_OFFSET, CFG_DATA_W'(ho));
		write_reg(CFG_PERIOD_OFFSET, CFG_DATA_W'(po));
		write_reg(CFG_EDGE_TIMEOUT, CFG_DATA_W'(to));
		write_reg(CFG_WARMUP_TICKS, CFG_DATA_W'(wu));
	endtask

	task automatic settle();
		do
			@(negedge clk);
		while (pin_backlog.size() != 0 || sample_ch.valid || readings_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// sample driver
	always @(posedge clk) begin
		logic nxt_valid, nxt_pin;
		if (arst_n) begin
			nxt_valid = sample_ch.valid;
			nxt_pin = sample_ch.pin_level;
			if (sample_ch.valid && sample_ch.ready) begin
				track_sample(sample_ch.pin_level);
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (idle_on && $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(0, 14);
				end else if (pin_backlog.size() > 0) begin
					nxt_valid = 1'b1;
					nxt_pin = pin_backlog.pop_front();
				end
			end
			sample_ch.valid <= nxt_valid;
			sample_ch.pin_level <= nxt_pin;
		end else begin
			sample_ch.valid <= 1'b0;
			sample_ch.pin_level <= 1'b0;
		end
	end

	// result monitor
	always @(posedge clk) begin
		reading_t got, want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				got.ppm = result_ch.ppm;
				got.status = result_ch.status;
				got.warming = result_ch.warming;
				if (readings_due.size() == 0) begin
					$error("unexpected item: ppm %0d status %0d warming %0b",
						got.ppm, got.status, got.warming);
					errors++;
				end else begin
					want = readings_due.pop_front();
					if (got.ppm !== want.ppm) begin
						$error("ppm: expected %0d, got %0d", want.ppm, got.ppm);
						errors++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						errors++;
					end
					if (got.warming !== want.warming) begin
						$error("warming: expected %0b, got %0b", want.warming, got.warming);
						errors++;
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				result_ch.ready <= 1'b0;
			end else if (stall_on && $urandom_range(0, 5) == 0) begin
				recv_gap = $urandom_range(0, 14);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end else begin
			result_ch.ready <= 1'b0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		int fs, ho, po, to, wu;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_FULL_SCALE;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults: pin high out of reset is no rise, short period is degenerate
		pin_backlog = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
		settle();

		// normal reading, fresh edge, then each timeout kind
		configure(10000, 0, 0, 3, 0);
		pin_backlog = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1,
			1'b0, 1'b1, 1'b1, 1'b1, 1'b1,
			1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
		settle();

		// zero timeout fires on every tick without the awaited edge
		configure(10000, 0, 0, 0, 0);
		pin_backlog = '{1'b1, 1'b0, 1'b1, 1'b1};
		settle();

		for (int p = 0; p < 9; p++) begin
			fs = $urandom_range(1, 10000);
			ho = $urandom_range(0, 6);
			po = $urandom_range(0, 12);
			to = $urandom_range(4, 40);
			wu = int'(warm_cnt) + $urandom_range(0, 300);
			case (p)
				0: begin
					fs = 1;
					to = 1;
					wu = int'(WARM_MAX);
				end
				1: begin
					fs = 10000;
					ho = 100000;
				end
				2: begin
					ho = 0;
					po = 100000;
				end
				3: begin
					to = 2000000;
					wu = 0;
					po = 0;
				end
				default: ;
			endcase
			idle_on = (p < 7) && ($urandom_range(0, 3) != 0);
			stall_on = (p < 7) && ($urandom_range(0, 3) != 0);
			configure(fs, ho, po, to, wu);
			queue_random(75);
			settle();
		end

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
